FILE: rtl/cpeq_pkg.sv
// shared types, sizes and codes for the coalescing packet event queue
// no dependencies; imported by cpeq_dp, cpeq_ctrl, the top level and the checker
package cpeq_pkg;

  localparam int QUEUE_DEPTH = 32;
  localparam int PACKET_MAX  = 100;
  localparam int SLOT_WORDS  = (PACKET_MAX + 3) / 4;
  localparam int STORE_DEPTH = QUEUE_DEPTH * SLOT_WORDS;
  localparam int BYTE_LANES  = 4;

  localparam int IDX_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int LEN_W  = $clog2(PACKET_MAX + 1);
  localparam int POS_W  = $clog2(PACKET_MAX + 4);
  localparam int WORD_W = $clog2(SLOT_WORDS + 1);
  localparam int ADDR_W = $clog2(STORE_DEPTH);
  localparam int CAP_W  = 16;

  // action codes
  localparam logic ACT_ENQ = 1'b0;
  localparam logic ACT_DEQ = 1'b1;

  // result status codes
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_EMPTY    = 2'd1;
  localparam logic [1:0] STATUS_TOO_LONG = 2'd2;
  localparam logic [1:0] STATUS_BUSY     = 2'd3;

  typedef struct packed {
    logic             action;
    logic             coalesce;
    logic [7:0]       in_byte0;
    logic [7:0]       in_byte1;
    logic [7:0]       in_byte2;
    logic [7:0]       in_byte3;
    logic [2:0]       in_count;
    logic             in_last;
    logic [CAP_W-1:0] read_capacity;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte0;
    logic [7:0] out_byte1;
    logic [7:0] out_byte2;
    logic [7:0] out_byte3;
    logic [2:0] out_count;
    logic       out_last;
    logic [6:0] entry_length;
    logic [1:0] status;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic enq_word;
    logic emit_busy;
    logic emit_empty;
    logic pop_head;
    logic emit_too_long;
    logic emit_zero;
    logic start_stream;
    logic stream_word;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_deq;
    logic enq_open;
    logic empty;
    logic too_long;
    logic len_zero;
    logic last_word;
  } dp_stat_t;

endpackage

FILE: rtl/cpeq_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module cpeq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/cpeq_dp.sv
// datapath: queue pointers, byte-lane packet store, length store, result register
// depends on cpeq_pkg and cpeq_ram
module cpeq_dp import cpeq_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_t       item_i,
  input  ctrl_cmd_t cmd_i,
  output dp_stat_t  stat_o,
  output logic      result_valid_o,
  output out_t      result_o
);

  logic [IDX_W-1:0]  head_q;
  logic [CNT_W-1:0]  count_q;
  logic              open_q;
  logic              drop_q;
  logic [IDX_W-1:0]  wslot_q;
  logic [LEN_W-1:0]  wpos_q;
  logic              tail_adv_q;
  logic [ADDR_W-1:0] rd_base_q;
  logic [CAP_W-1:0]  cap_q;
  logic [LEN_W-1:0]  len_q;
  logic [WORD_W-1:0] word_q;
  out_t              res_d, res_q;
  logic              res_valid_d, res_valid_q;

  logic [CNT_W:0]    sum_hc;
  logic [IDX_W-1:0]  tail_idx, head_inc, new_slot;
  logic              full, empty, coal_hit;
  logic [IDX_W-1:0]  claim_slot, head_claim;
  logic [CNT_W-1:0]  count_claim;
  logic              claim_drop;
  logic              first;
  logic [IDX_W-1:0]  cur_slot;
  logic [LEN_W-1:0]  cur_pos;
  logic              cur_drop;
  logic [2:0]        n_eff;
  logic [POS_W-1:0]  pos_end;
  logic [LEN_W-1:0]  new_pos;
  logic [ADDR_W-1:0] wr_base, rd_addr;
  logic              wr_en;
  logic [LEN_W-1:0]  len_rd;
  logic [LEN_W:0]    remain;
  logic              last_word;
  logic [2:0]        word_cnt;
  logic [7:0]        lane_rdata [BYTE_LANES];

  function automatic logic [IDX_W-1:0] wrap_idx(input logic [CNT_W:0] v);
    if (v >= (CNT_W+1)'(QUEUE_DEPTH)) begin
      return IDX_W'(v - (CNT_W+1)'(QUEUE_DEPTH));
    end
    return IDX_W'(v);
  endfunction

  assign sum_hc   = (CNT_W+1)'(head_q) + (CNT_W+1)'(count_q);
  assign tail_idx = wrap_idx(sum_hc - (CNT_W+1)'(1));
  assign new_slot = wrap_idx(sum_hc);
  assign head_inc = wrap_idx((CNT_W+1)'(head_q) + (CNT_W+1)'(1));
  assign full     = (count_q == CNT_W'(QUEUE_DEPTH));
  assign empty    = (count_q == '0);
  assign coal_hit = item_i.coalesce && !empty && tail_adv_q;

  // slot claim on the first word of a packet
  always_comb begin
    claim_slot  = new_slot;
    head_claim  = head_q;
    count_claim = count_q;
    claim_drop  = 1'b0;
    priority if (coal_hit) begin
      claim_slot  = tail_idx;
    end else if (full && item_i.coalesce) begin
      claim_drop  = 1'b1;
    end else if (full) begin
      claim_slot  = head_q;
      head_claim  = head_inc;
    end else begin
      count_claim = count_q + CNT_W'(1);
    end
  end

  assign first    = !open_q;
  assign cur_slot = first ? claim_slot : wslot_q;
  assign cur_pos  = first ? '0 : wpos_q;
  assign cur_drop = first ? claim_drop : drop_q;
  assign n_eff    = (item_i.in_count > 3'd4) ? 3'd4 : item_i.in_count;
  assign pos_end  = POS_W'(cur_pos) + POS_W'(n_eff);
  assign new_pos  = (pos_end > POS_W'(PACKET_MAX)) ? LEN_W'(PACKET_MAX) : LEN_W'(pos_end);
  assign wr_base  = ADDR_W'(cur_slot) * ADDR_W'(SLOT_WORDS);
  assign wr_en    = cmd_i.enq_word && !cur_drop;

  // dequeue word stream
  assign remain    = (LEN_W+1)'(len_q) - (LEN_W+1)'({word_q, 2'b00});
  assign last_word = (remain <= (LEN_W+1)'(4));
  assign word_cnt  = last_word ? 3'(remain) : 3'd4;
  assign rd_addr   = (cmd_i.stream_word && !last_word) ?
                     rd_base_q + ADDR_W'(word_q) + ADDR_W'(1) : rd_base_q;

  // one ram per byte lane so all bytes of an unaligned word are written together
  for (genvar l = 0; l < BYTE_LANES; l++) begin : g_lane
    logic [1:0]        lane_sel;
    logic [POS_W-1:0]  lane_pos;
    logic              lane_we;
    logic [ADDR_W-1:0] lane_waddr;
    logic [7:0]        lane_wdata;

    assign lane_sel   = 2'(l) - cur_pos[1:0];
    assign lane_pos   = POS_W'(cur_pos) + POS_W'(lane_sel);
    assign lane_we    = wr_en && ({1'b0, lane_sel} < n_eff) &&
                        (lane_pos < POS_W'(PACKET_MAX));
    assign lane_waddr = wr_base + ADDR_W'(lane_pos >> 2);

    always_comb begin
      unique case (lane_sel)
        2'd0:    lane_wdata = item_i.in_byte0;
        2'd1:    lane_wdata = item_i.in_byte1;
        2'd2:    lane_wdata = item_i.in_byte2;
        default: lane_wdata = item_i.in_byte3;
      endcase
    end

    cpeq_ram #(
      .WIDTH (8),
      .DEPTH (STORE_DEPTH)
    ) u_lane_ram (
      .clk_i   (clk_i),
      .we_i    (lane_we),
      .waddr_i (lane_waddr),
      .wdata_i (lane_wdata),
      .raddr_i (rd_addr),
      .rdata_o (lane_rdata[l])
    );
  end

  cpeq_ram #(
    .WIDTH (LEN_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_len_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (cur_slot),
    .wdata_i (new_pos),
    .raddr_i (head_q),
    .rdata_o (len_rd)
  );

  always_comb begin
    stat_o.is_deq    = (item_i.action == ACT_DEQ);
    stat_o.enq_open  = open_q;
    stat_o.empty     = empty;
    stat_o.too_long  = (CAP_W'(len_rd) > cap_q);
    stat_o.len_zero  = (len_rd == '0);
    stat_o.last_word = last_word;
  end

  // result word
  always_comb begin
    res_d       = '0;
    res_valid_d = 1'b1;
    priority if (cmd_i.emit_busy) begin
      res_d.status   = STATUS_BUSY;
      res_d.out_last = 1'b1;
    end else if (cmd_i.emit_empty) begin
      res_d.status   = STATUS_EMPTY;
      res_d.out_last = 1'b1;
    end else if (cmd_i.emit_too_long) begin
      res_d.status       = STATUS_TOO_LONG;
      res_d.entry_length = 7'(len_rd);
      res_d.out_last     = 1'b1;
    end else if (cmd_i.emit_zero) begin
      res_d.status   = STATUS_OK;
      res_d.out_last = 1'b1;
    end else if (cmd_i.stream_word) begin
      res_d.status       = STATUS_OK;
      res_d.out_byte0    = lane_rdata[0];
      res_d.out_byte1    = (word_cnt > 3'd1) ? lane_rdata[1] : 8'd0;
      res_d.out_byte2    = (word_cnt > 3'd2) ? lane_rdata[2] : 8'd0;
      res_d.out_byte3    = (word_cnt > 3'd3) ? lane_rdata[3] : 8'd0;
      res_d.out_count    = word_cnt;
      res_d.out_last     = last_word;
      res_d.entry_length = 7'(len_q);
    end else begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      count_q     <= '0;
      open_q      <= 1'b0;
      drop_q      <= 1'b0;
      wslot_q     <= '0;
      wpos_q      <= '0;
      tail_adv_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
      if (cmd_i.enq_word) begin
        open_q <= !item_i.in_last;
        drop_q <= item_i.in_last ? 1'b0 : cur_drop;
        if (!cur_drop) begin
          wslot_q <= cur_slot;
          wpos_q  <= new_pos;
        end
        if (first && !claim_drop) begin
          head_q     <= head_claim;
          count_q    <= count_claim;
          tail_adv_q <= item_i.coalesce;
        end
      end else if (cmd_i.pop_head) begin
        head_q  <= head_inc;
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (cmd_i.pop_head) begin
      rd_base_q <= ADDR_W'(head_q) * ADDR_W'(SLOT_WORDS);
      cap_q     <= item_i.read_capacity;
    end
    if (cmd_i.start_stream) begin
      len_q  <= len_rd;
      word_q <= '0;
    end else if (cmd_i.stream_word) begin
      word_q <= word_q + WORD_W'(1);
    end
  end

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

endmodule

FILE: rtl/cpeq_ctrl.sv
// controller state machine: sequences enqueue words and dequeue runs
// depends on cpeq_pkg
module cpeq_ctrl import cpeq_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  dp_stat_t  stat_i,
  output ctrl_cmd_t cmd_o,
  output logic      busy_o
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_LEN    = 2'd1;
  localparam logic [1:0] S_STREAM = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          priority if (!stat_i.is_deq) begin
            cmd_o.enq_word = 1'b1;
          end else if (stat_i.enq_open) begin
            cmd_o.emit_busy = 1'b1;
          end else if (stat_i.empty) begin
            cmd_o.emit_empty = 1'b1;
          end else begin
            cmd_o.pop_head = 1'b1;
            state_d        = S_LEN;
          end
        end
      end
      S_LEN: begin
        priority if (stat_i.too_long) begin
          cmd_o.emit_too_long = 1'b1;
          state_d             = S_IDLE;
        end else if (stat_i.len_zero) begin
          cmd_o.emit_zero = 1'b1;
          state_d         = S_IDLE;
        end else begin
          cmd_o.start_stream = 1'b1;
          state_d            = S_STREAM;
        end
      end
      S_STREAM: begin
        cmd_o.stream_word = 1'b1;
        if (stat_i.last_word) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

FILE: rtl/coalescing_packet_event_queue.sv
// top level of the coalescing packet event queue
// depends on cpeq_pkg, cpeq_ctrl, cpeq_dp (and through it cpeq_ram)
//
// command channel: a beat is taken at a clock edge with start high and busy low.
//   action 0 writes one enqueue word (up to four bytes), action 1 asks for a pop.
// result channel: result_valid_o strobes each result beat for one cycle only;
//   the receiver cannot stall, so every beat must be taken when shown.
// enqueue words give no result; busy stays low, so a
//   packet streams in at one word per clock.
// a pop on an empty queue or while a packet is still open gives a single status
//   beat in the cycle after the command, with busy staying low.
// a real pop first fetches the stored length from the length ram in S_LEN, then
//   streams one beat per cycle from the byte-lane packet rams in S_STREAM, with
//   busy high throughout; a first word beat passes the length ram read, the lane
//   ram read and the result register, a status beat only the result register; an
//   over-capacity or zero-length entry gives one beat after the length ram read.
// the registered read of the length ram is why S_LEN comes before the first word.
// reset clears pointers, counts and the open/drop flags; the packet and length
//   rams hold whatever they held, and nothing reads an entry that was not written.
module coalescing_packet_event_queue import cpeq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  in_t  item_i,
  output logic result_valid_o,
  output out_t result_o
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // sequencing of each command
  cpeq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy_o (busy)
  );

  // queue state, stores and result register
  cpeq_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_i         (item_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

FILE: rtl/cpeq_checker.sv
// port-level checker for the coalescing packet event queue, bound to the top level
// depends on cpeq_pkg and coalescing_packet_event_queue
module cpeq_checker import cpeq_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input in_t  item_i,
  input logic result_valid_o,
  input out_t result_o
);

  // a run of words never breaks off before its last beat
  a_run_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_o.out_last |=> result_valid_o)
    else $error("dequeue run broken before last beat");

  // only the final beat of a run may be short
  a_inner_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_o.out_last |->
      result_o.out_count == 3'd4 && result_o.status == STATUS_OK)
    else $error("inner beat not a full ok word");

  // status beats carry no bytes and close the run
  a_status_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.status != STATUS_OK |->
      result_o.out_last && result_o.out_count == 3'd0 &&
      result_o.out_byte0 == 8'd0 && result_o.out_byte3 == 8'd0)
    else $error("status beat with payload");

  // an enqueue word never causes a result
  a_enq_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && item_i.action == ACT_ENQ |=> !result_valid_o)
    else $error("result after enqueue word");

endmodule

bind coalescing_packet_event_queue cpeq_checker u_cpeq_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .item_i         (item_i),
  .result_valid_o (result_valid_o),
  .result_o       (result_o)
);
